// ----- src/rpn_stack_calculator_macros.svh -----
// assertion macros for the rpn stack calculator
`ifndef RPN_STACK_CALCULATOR_MACROS_SVH
`define RPN_STACK_CALCULATOR_MACROS_SVH

`ifndef SYNTH
// same-cycle implication under synchronous active-low reset
`define RSC_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
// next-cycle implication under synchronous active-low reset
`define RSC_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define RSC_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define RSC_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

// ----- src/rsc_pkg.sv -----
// shared types and constants of the rpn stack calculator
package rsc_pkg;

    localparam int DATA_W   = 32;
    localparam int KIND_W   = 3;
    localparam int STATUS_W = 2;
    localparam int DEPTH_W  = 3;

    typedef logic signed [DATA_W-1:0] t_word;

    // command codes of an input word
    typedef enum logic [KIND_W-1:0] {
        K_PUSH  = 3'd0,
        K_ADD   = 3'd1,
        K_SUB   = 3'd2,
        K_MUL   = 3'd3,
        K_DIV   = 3'd4,
        K_CLEAR = 3'd5
    } t_kind;

    // status codes of a result word
    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_FEW     = 2'd2,
        ST_DIVZERO = 2'd3
    } t_status;

endpackage

// ----- src/rsc_stack_ram.sv -----
// stack storage: one write port, two registered read ports
module rsc_stack_ram #(
    parameter int  DEPTH = 4,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  rsc_pkg::t_word i_wdata,
    input  logic [AW-1:0] i_raddr0,
    input  logic [AW-1:0] i_raddr1,
    output rsc_pkg::t_word o_rdata0,
    output rsc_pkg::t_word o_rdata1
);

    rsc_pkg::t_word r_mem [DEPTH];
    rsc_pkg::t_word r_rdata0;
    rsc_pkg::t_word r_rdata1;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read ports, registered
    always_ff @(posedge i_clk) begin
        r_rdata0 <= r_mem[i_raddr0];
        r_rdata1 <= r_mem[i_raddr1];
    end

    assign o_rdata0 = r_rdata0;
    assign o_rdata1 = r_rdata1;

endmodule

// ----- src/rsc_divider.sv -----
// signed truncating divider, one quotient bit per cycle
module rsc_divider (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  rsc_pkg::t_word i_dividend,
    input  rsc_pkg::t_word i_divisor,
    output logic           o_done,
    output rsc_pkg::t_word o_quotient
);

    localparam int W  = rsc_pkg::DATA_W;
    localparam int CW = $clog2(W);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [W-1:0]  r_rem;
    logic [W-1:0]  r_quo;
    logic [W-1:0]  r_den;
    logic          r_neg;

    logic [W:0]    w_shift;
    logic [W:0]    w_diff;
    logic [W-1:0]  w_abs_num;
    logic [W-1:0]  w_abs_den;

    // magnitudes of the operands
    assign w_abs_num = i_dividend[W-1] ? ({W{1'b0}} - W'(i_dividend)) : W'(i_dividend);
    assign w_abs_den = i_divisor[W-1]  ? ({W{1'b0}} - W'(i_divisor))  : W'(i_divisor);

    // restoring step: shift in next dividend bit, trial subtract
    assign w_shift = {r_rem, r_quo[W-1]};
    assign w_diff  = w_shift - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_quo  <= w_abs_num;
                r_den  <= w_abs_den;
                r_neg  <= i_dividend[W-1] ^ i_divisor[W-1];
            end else if (r_busy) begin
                r_rem <= w_diff[W] ? w_shift[W-1:0] : w_diff[W-1:0];
                r_quo <= {r_quo[W-2:0], ~w_diff[W]};
                r_cnt <= r_cnt + CW'(1);
                if (r_cnt == CW'(W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // sign correction of the quotient
    assign o_quotient = r_neg ? ({W{1'b0}} - r_quo) : r_quo;
    assign o_done     = r_done;

endmodule

// ----- src/rpn_stack_calculator.sv -----
// rpn stack calculator top level: command sequencer, stack memory and result register
// the sequencer handles one word at a time
// divide time is set by the 32-step divider, one quotient bit per cycle
// a result word waits in the output register while the next input word is taken
// reset (synchronous, active low) empties the stack and drops any pending result; no clearing pass
`include "rpn_stack_calculator_macros.svh"

module rpn_stack_calculator #(
    parameter int STACK_DEPTH = 4
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [rsc_pkg::KIND_W-1:0]      i_kind,
    input  logic signed [rsc_pkg::DATA_W-1:0] i_value,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [rsc_pkg::STATUS_W-1:0]    o_status,
    output logic signed [rsc_pkg::DATA_W-1:0] o_top_value,
    output logic [rsc_pkg::DEPTH_W-1:0]     o_depth
);

    localparam int DW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_DIV,
        S_FIN
    } t_state;

    t_state                         r_state,      n_state;
    logic [DW-1:0]                  r_depth,      n_depth;
    rsc_pkg::t_word                 r_top,        n_top;
    rsc_pkg::t_kind                 r_kind,       n_kind;
    rsc_pkg::t_status               r_status,     n_status;
    logic                           r_out_valid,  n_out_valid;
    rsc_pkg::t_status               r_out_status, n_out_status;
    rsc_pkg::t_word                 r_out_top,    n_out_top;
    logic [rsc_pkg::DEPTH_W-1:0]    r_out_depth,  n_out_depth;

    logic           w_in_acc;
    logic [DW-1:0]  w_dm1;
    logic [DW-1:0]  w_dm2;
    logic [DW-1:0]  w_dm3;
    logic           w_mem_we;
    logic [AW-1:0]  w_mem_waddr;
    rsc_pkg::t_word w_mem_wdata;
    rsc_pkg::t_word w_next;
    rsc_pkg::t_word w_below;
    rsc_pkg::t_word w_alu;
    logic           w_div_start;
    logic           w_div_done;
    rsc_pkg::t_word w_quot;

    // input handshake
    assign w_in_acc   = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);

    // depth arithmetic for stack addressing
    assign w_dm1 = r_depth - DW'(1);
    assign w_dm2 = r_depth - DW'(2);
    assign w_dm3 = r_depth - DW'(3);

    // stack memory: read the entry below the top and the one under it
    rsc_stack_ram #(
        .DEPTH (STACK_DEPTH)
    ) u_ram (
        .i_clk    (i_clk),
        .i_we     (w_mem_we),
        .i_waddr  (w_mem_waddr),
        .i_wdata  (w_mem_wdata),
        .i_raddr0 (w_dm2[AW-1:0]),
        .i_raddr1 (w_dm3[AW-1:0]),
        .o_rdata0 (w_next),
        .o_rdata1 (w_below)
    );

    // add, subtract, multiply of top and next
    always_comb begin
        case (r_kind)
            rsc_pkg::K_ADD: w_alu = r_top + w_next;
            rsc_pkg::K_SUB: w_alu = r_top - w_next;
            default:        w_alu = r_top * w_next;
        endcase
    end

    // divider, started once the divisor is known to be nonzero
    assign w_div_start = (r_state == S_EXEC) && (r_kind == rsc_pkg::K_DIV) && (w_next != '0);

    rsc_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_top),
        .i_divisor  (w_next),
        .o_done     (w_div_done),
        .o_quotient (w_quot)
    );

    // sequencer: one word at a time, so memory reads never overlap a write
    always_comb begin
        n_state      = r_state;
        n_depth      = r_depth;
        n_top        = r_top;
        n_kind       = r_kind;
        n_status     = r_status;
        n_out_valid  = r_out_valid;
        n_out_status = r_out_status;
        n_out_top    = r_out_top;
        n_out_depth  = r_out_depth;
        w_mem_we     = 1'b0;
        w_mem_waddr  = w_dm2[AW-1:0];
        w_mem_wdata  = w_alu;

        // result word taken downstream
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_kind   = rsc_pkg::t_kind'(i_kind);
                    n_status = rsc_pkg::ST_OK;
                    n_state  = S_FIN;
                    case (i_kind)
                        rsc_pkg::K_PUSH: begin
                            if (r_depth == DW'(STACK_DEPTH)) begin
                                n_status = rsc_pkg::ST_FULL;
                            end else begin
                                w_mem_we    = 1'b1;
                                w_mem_waddr = r_depth[AW-1:0];
                                w_mem_wdata = i_value;
                                n_top       = i_value;
                                n_depth     = r_depth + DW'(1);
                            end
                        end
                        rsc_pkg::K_ADD, rsc_pkg::K_SUB, rsc_pkg::K_MUL, rsc_pkg::K_DIV: begin
                            if (r_depth < DW'(2)) begin
                                n_status = rsc_pkg::ST_FEW;
                            end else begin
                                n_state = S_EXEC;
                            end
                        end
                        rsc_pkg::K_CLEAR: begin
                            n_depth = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_EXEC: begin
                if (r_kind == rsc_pkg::K_DIV) begin
                    if (w_next == '0) begin
                        // zero divisor drops both operands
                        n_depth  = w_dm2;
                        n_top    = w_below;
                        n_status = rsc_pkg::ST_DIVZERO;
                        n_state  = S_FIN;
                    end else begin
                        n_state = S_DIV;
                    end
                end else begin
                    w_mem_we = 1'b1;
                    n_top    = w_alu;
                    n_depth  = w_dm1;
                    n_state  = S_FIN;
                end
            end
            S_DIV: begin
                if (w_div_done) begin
                    w_mem_we    = 1'b1;
                    w_mem_wdata = w_quot;
                    n_top       = w_quot;
                    n_depth     = w_dm1;
                    n_state     = S_FIN;
                end
            end
            S_FIN: begin
                // load the output register once it is free
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_top    = (r_depth == '0) ? '0 : r_top;
                    n_out_depth  = rsc_pkg::DEPTH_W'(r_depth);
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_depth     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_depth      <= n_depth;
            r_top        <= n_top;
            r_kind       <= n_kind;
            r_status     <= n_status;
            r_out_valid  <= n_out_valid;
            r_out_status <= n_out_status;
            r_out_top    <= n_out_top;
            r_out_depth  <= n_out_depth;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_out_status;
    assign o_top_value = r_out_top;
    assign o_depth     = r_out_depth;

    // checks
    `RSC_ASSERT_IMP(a_depth_bound, i_clk, i_rst_n, 1'b1, r_depth <= DW'(STACK_DEPTH), "stack depth beyond capacity")
    `RSC_ASSERT_IMP(a_div_done_state, i_clk, i_rst_n, w_div_done, r_state == S_DIV, "divider finished outside divide state")
    `RSC_ASSERT_IMP(a_no_push_full, i_clk, i_rst_n, w_mem_we && r_state == S_IDLE, r_depth < DW'(STACK_DEPTH), "push written into full stack")
    `RSC_ASSERT_NXT(a_push_grows, i_clk, i_rst_n, w_in_acc && i_kind == rsc_pkg::K_PUSH && r_depth < DW'(STACK_DEPTH), r_depth == $past(r_depth) + DW'(1), "push did not grow the stack")
    `RSC_ASSERT_NXT(a_out_load, i_clk, i_rst_n, r_state == S_FIN && (!r_out_valid || !i_out_stall), o_out_valid && r_state == S_IDLE, "result word not loaded from finish state")

endmodule
